FILE: rtl/lrm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Link traffic rate meter: shared definitions
// Request codes, field widths, record types and the constants of the three
// low-pass time constants used by the rate meter.
// ----------------------------------------------------------------------------
package lrm_pkg;

  localparam int CNT_W   = 32;
  localparam int LEN_W   = 11;
  localparam int REQ_W   = 3;
  localparam int IDX_W   = 2;
  localparam int MAX_INTERVALS     = 3;
  localparam int NUM_INTERVALS_DEF = 3;
  localparam int FIFO_DEPTH_DEF    = 8;

  localparam logic [CNT_W-1:0] HEADER_BYTES = 32'd14;
  localparam logic [CNT_W-1:0] FRAME_SCALE  = 32'd1000;

  // Each time constant is an odd divisor times a power of two. The magnitude
  // is shifted first, then divided by the odd part through a reciprocal.
  localparam int MAG_W    = 29;
  localparam int RECIP_W  = 26;
  localparam int RECIP_SH = 32;
  localparam int QUO_W    = MAG_W + RECIP_W - RECIP_SH;
  localparam int ODD_W    = 11;
  localparam int SHIFT_W  = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_SENT  = 3'd0,
    REQ_FAIL  = 3'd1,
    REQ_RECV  = 3'd2,
    REQ_TICK  = 3'd3,
    REQ_CLEAR = 3'd4
  } req_t;

  typedef logic [IDX_W-1:0] slot_t;

  localparam slot_t LAST_SLOT = slot_t'(MAX_INTERVALS - 1);

  typedef struct packed {
    logic [CNT_W-1:0] sent_frames;
    logic [CNT_W-1:0] recv_frames;
    logic [CNT_W-1:0] send_failures;
    logic [CNT_W-1:0] sent_bytes;
    logic [CNT_W-1:0] recv_bytes;
  } totals_t;

  typedef struct packed {
    logic [CNT_W-1:0] sent_frame;
    logic [CNT_W-1:0] recv_frame;
    logic [CNT_W-1:0] sent_byte;
    logic [CNT_W-1:0] recv_byte;
  } qty_t;

  typedef struct packed {
    logic  vld;
    slot_t idx;
  } stage_t;

  typedef struct packed {
    stage_t s0;
    stage_t s1;
    stage_t s2;
  } lane_ctl_t;

  typedef struct packed {
    slot_t   idx;
    qty_t    rates;
    totals_t totals;
    logic    last;
  } result_t;

  // 1000 = 125 << 3, 3000 = 375 << 3, 60000 = 1875 << 5.
  function automatic logic [SHIFT_W-1:0] tau_shift(input slot_t idx);
    logic [SHIFT_W-1:0] sh;
    case (idx)
      2'd2:    sh = 3'd5;
      default: sh = 3'd3;
    endcase
    return sh;
  endfunction

  function automatic logic [ODD_W-1:0] tau_odd(input slot_t idx);
    logic [ODD_W-1:0] d;
    case (idx)
      2'd1:    d = 11'd375;
      2'd2:    d = 11'd1875;
      default: d = 11'd125;
    endcase
    return d;
  endfunction

  // floor(2^32 / odd part); the estimate is at most one below the quotient.
  function automatic logic [RECIP_W-1:0] tau_recip(input slot_t idx);
    logic [RECIP_W-1:0] m;
    case (idx)
      2'd1:    m = 26'd11453246;
      2'd2:    m = 26'd2290649;
      default: m = 26'd34359738;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/lrm_counters.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Link traffic rate meter: event counters
// Keeps the wrapping totals, the totals seen at the last tick, and on a tick
// registers the changes (frame changes scaled) and a snapshot of the totals.
// ----------------------------------------------------------------------------
module lrm_counters (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      acc,
  input  wire logic [lrm_pkg::REQ_W-1:0] req,
  input  wire logic [lrm_pkg::LEN_W-1:0] len,
  output lrm_pkg::totals_t               snap,
  output lrm_pkg::qty_t                  x
);
  import lrm_pkg::*;

  totals_t          tot_r, tot_nxt;
  qty_t             prev_r, prev_nxt;
  totals_t          snap_r, snap_nxt;
  qty_t             x_r, x_nxt;
  logic [CNT_W-1:0] len_ext;

  assign len_ext = {{(CNT_W-LEN_W){1'b0}}, len};

  always_comb begin
    tot_nxt  = tot_r;
    prev_nxt = prev_r;
    snap_nxt = snap_r;
    x_nxt    = x_r;
    if (acc) begin
      case (req)
        REQ_SENT: begin
          tot_nxt.sent_frames = tot_r.sent_frames + 1'b1;
          tot_nxt.sent_bytes  = tot_r.sent_bytes + len_ext + HEADER_BYTES;
        end
        REQ_FAIL: begin
          tot_nxt.send_failures = tot_r.send_failures + 1'b1;
        end
        REQ_RECV: begin
          // A zero length means nothing arrived.
          if (len != '0) begin
            tot_nxt.recv_frames = tot_r.recv_frames + 1'b1;
            tot_nxt.recv_bytes  = tot_r.recv_bytes + len_ext;
          end
        end
        REQ_TICK: begin
          x_nxt.sent_frame = (tot_r.sent_frames - prev_r.sent_frame) * FRAME_SCALE;
          x_nxt.recv_frame = (tot_r.recv_frames - prev_r.recv_frame) * FRAME_SCALE;
          x_nxt.sent_byte  = tot_r.sent_bytes - prev_r.sent_byte;
          x_nxt.recv_byte  = tot_r.recv_bytes - prev_r.recv_byte;
          prev_nxt.sent_frame = tot_r.sent_frames;
          prev_nxt.recv_frame = tot_r.recv_frames;
          prev_nxt.sent_byte  = tot_r.sent_bytes;
          prev_nxt.recv_byte  = tot_r.recv_bytes;
          snap_nxt = tot_r;
        end
        REQ_CLEAR: begin
          tot_nxt  = '0;
          prev_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_r  <= '0;
      prev_r <= '0;
    end else begin
      tot_r  <= tot_nxt;
      prev_r <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    snap_r <= snap_nxt;
    x_r    <= x_nxt;
  end

  assign snap = snap_r;
  assign x    = x_r;

endmodule
`default_nettype wire

FILE: rtl/lrm_avg_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Link traffic rate meter: averaging lane
// Holds the averages of one quantity and updates one of them per slot in a
// three-stage pipeline: difference and magnitude, reciprocal multiply, then
// quotient correction and write-back.
// ----------------------------------------------------------------------------
module lrm_avg_lane (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      clear,
  input  wire lrm_pkg::lane_ctl_t        ctl,
  input  wire logic [lrm_pkg::CNT_W-1:0] x,
  output logic [lrm_pkg::CNT_W-1:0]      avg_new
);
  import lrm_pkg::*;

  logic [CNT_W-1:0]         avg_r [MAX_INTERVALS];
  logic [CNT_W-1:0]         avg_s0, avg_s2;
  logic [CNT_W:0]           diff, mag;
  logic [CNT_W-1:0]         shifted;
  logic [MAG_W-1:0]         a_mag_r, a_mag_nxt, b_mag_r;
  logic                     a_neg_r, a_neg_nxt, b_neg_r;
  logic [MAG_W+RECIP_W-1:0] prod;
  logic [QUO_W-1:0]         b_quo_r, b_quo_nxt, quo;
  logic [ODD_W-1:0]         odd_s2;
  logic [QUO_W+ODD_W-1:0]   back;
  logic [MAG_W-1:0]         rem;
  logic [CNT_W-1:0]         quo_ext, step;

  // Stage 0: exact 33-bit difference, split into sign and magnitude.
  always_comb begin
    avg_s0    = avg_r[ctl.s0.idx];
    diff      = {x[CNT_W-1], x} - {avg_s0[CNT_W-1], avg_s0};
    a_neg_nxt = diff[CNT_W];
    mag       = a_neg_nxt ? (~diff + 1'b1) : diff;
    shifted   = mag[CNT_W-1:0] >> tau_shift(ctl.s0.idx);
    a_mag_nxt = shifted[MAG_W-1:0];
  end

  // Stage 1: quotient estimate from the reciprocal.
  always_comb begin
    prod      = a_mag_r * tau_recip(ctl.s1.idx);
    b_quo_nxt = prod[MAG_W+RECIP_W-1:RECIP_SH];
  end

  // Stage 2: the estimate is low by at most one; fix it, restore the sign
  // (truncation toward zero) and step the average.
  always_comb begin
    odd_s2  = tau_odd(ctl.s2.idx);
    back    = b_quo_r * odd_s2;
    rem     = b_mag_r - back[MAG_W-1:0];
    quo     = b_quo_r + QUO_W'(rem >= {{(MAG_W-ODD_W){1'b0}}, odd_s2});
    quo_ext = {{(CNT_W-QUO_W){1'b0}}, quo};
    step    = b_neg_r ? (~quo_ext + 1'b1) : quo_ext;
    avg_s2  = avg_r[ctl.s2.idx];
    avg_new = avg_s2 + step;
  end

  always_ff @(posedge clk) begin
    a_mag_r <= a_mag_nxt;
    a_neg_r <= a_neg_nxt;
    b_mag_r <= a_mag_r;
    b_neg_r <= a_neg_r;
    b_quo_r <= b_quo_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      for (int i = 0; i < MAX_INTERVALS; i++) begin
        avg_r[i] <= '0;
      end
    end else if (ctl.s2.vld) begin
      avg_r[ctl.s2.idx] <= avg_new;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/lrm_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Link traffic rate meter: result queue
// Small first-in first-out store of finished result words, read at its head.
// ----------------------------------------------------------------------------
module lrm_fifo #(
  parameter int DEPTH = lrm_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire lrm_pkg::result_t wdata,
  input  wire logic             pop,
  output lrm_pkg::result_t      rdata,
  output logic                  not_empty
);
  import lrm_pkg::*;

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  result_t           mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      fill_nxt   = fill_nxt + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      fill_nxt   = fill_nxt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  assign rdata     = mem[rd_ptr_r];
  assign not_empty = (fill_r != '0);

endmodule
`default_nettype wire

FILE: rtl/link_traffic_rate_meter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Link traffic rate meter
// Counts sent and received frames and bytes and failed sends, and on each update tick
// emits low-pass filtered rates for each time constant.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake          Word
//  in_      input      in_valid/in_stall  in_req_type, in_byte_count
//  out_     output     out_valid/out_stall interval index, four rates, five totals, last
//
//  Count and failure words are taken every cycle and never stalled. A tick issues one
//  averaging slot per cycle over three slots; the next tick can be taken while the last
//  slot of the previous one issues. The tick's changes are registered, then each slot
//  passes the lane stages before its word is queued. A tick is also held while the
//  result queue lacks room for all its words; a clear is held until the pipeline drains.
//  Reset clears all totals and averages; it is synchronous and active low.
// ----------------------------------------------------------------------------
module link_traffic_rate_meter #(
  parameter int NUM_INTERVALS = lrm_pkg::NUM_INTERVALS_DEF,
  parameter int FIFO_DEPTH    = lrm_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [lrm_pkg::REQ_W-1:0] in_req_type,
  input  wire logic [lrm_pkg::LEN_W-1:0] in_byte_count,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [lrm_pkg::IDX_W-1:0]      out_interval_index,
  output logic signed [lrm_pkg::CNT_W-1:0] out_sent_frame_rate,
  output logic signed [lrm_pkg::CNT_W-1:0] out_recv_frame_rate,
  output logic signed [lrm_pkg::CNT_W-1:0] out_sent_byte_rate,
  output logic signed [lrm_pkg::CNT_W-1:0] out_recv_byte_rate,
  output logic [lrm_pkg::CNT_W-1:0]      out_sent_frames,
  output logic [lrm_pkg::CNT_W-1:0]      out_recv_frames,
  output logic [lrm_pkg::CNT_W-1:0]      out_send_failures,
  output logic [lrm_pkg::CNT_W-1:0]      out_sent_bytes,
  output logic [lrm_pkg::CNT_W-1:0]      out_recv_bytes,
  output logic                           out_last
);
  import lrm_pkg::*;

  localparam int CRED_W = $clog2(FIFO_DEPTH + 1);
  localparam slot_t FINAL_SLOT = slot_t'(NUM_INTERVALS - 1);
  localparam logic [CRED_W:0] TICK_COST = NUM_INTERVALS[CRED_W:0];
  localparam logic [CRED_W:0] DEPTH_CAP = FIFO_DEPTH[CRED_W:0];

  logic              in_acc, tick_acc, clear_acc;
  logic              tick_ok, clear_ok, room;
  logic              iss_act_r, iss_act_nxt;
  slot_t             iss_slot_r, iss_slot_nxt;
  stage_t            s0_ctl, a_ctl_r, b_ctl_r;
  lane_ctl_t         lane_ctl;
  totals_t           snap, a_tot_r, b_tot_r;
  qty_t              x, avg_new;
  result_t           res, head;
  logic              out_pop;
  logic [CRED_W-1:0] cred_r, cred_nxt;

  // Only tick and clear words can be held back.
  assign room     = ({1'b0, cred_r} + TICK_COST) <= DEPTH_CAP;
  assign tick_ok  = (!iss_act_r || iss_slot_r == LAST_SLOT) && room;
  assign clear_ok = !iss_act_r && !a_ctl_r.vld && !b_ctl_r.vld;
  assign in_stall = ((in_req_type == REQ_TICK) && !tick_ok) ||
                    ((in_req_type == REQ_CLEAR) && !clear_ok);
  assign in_acc    = in_valid && !in_stall;
  assign tick_acc  = in_acc && (in_req_type == REQ_TICK);
  assign clear_acc = in_acc && (in_req_type == REQ_CLEAR);

  lrm_counters u_counters (
    .clk  (clk),
    .rst_n(rst_n),
    .acc  (in_acc),
    .req  (in_req_type),
    .len  (in_byte_count),
    .snap (snap),
    .x    (x)
  );

  // Slot sequencer: three slots per tick, unused slots pass as bubbles.
  always_comb begin
    iss_act_nxt  = iss_act_r;
    iss_slot_nxt = iss_slot_r;
    if (iss_act_r && iss_slot_r != LAST_SLOT) begin
      iss_slot_nxt = iss_slot_r + 1'b1;
    end else begin
      iss_act_nxt  = tick_acc;
      iss_slot_nxt = '0;
    end
  end

  assign s0_ctl.vld = iss_act_r && (iss_slot_r <= FINAL_SLOT);
  assign s0_ctl.idx = iss_slot_r;

  assign lane_ctl.s0 = s0_ctl;
  assign lane_ctl.s1 = a_ctl_r;
  assign lane_ctl.s2 = b_ctl_r;

  always_comb begin
    cred_nxt = cred_r;
    if (tick_acc) begin
      cred_nxt = cred_nxt + TICK_COST[CRED_W-1:0];
    end
    if (out_pop) begin
      cred_nxt = cred_nxt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_act_r  <= 1'b0;
      iss_slot_r <= '0;
      a_ctl_r    <= '0;
      b_ctl_r    <= '0;
      cred_r     <= '0;
    end else begin
      iss_act_r  <= iss_act_nxt;
      iss_slot_r <= iss_slot_nxt;
      a_ctl_r    <= s0_ctl;
      b_ctl_r    <= a_ctl_r;
      cred_r     <= cred_nxt;
    end
  end

  // The snapshot moves on with the next tick, so it travels with the slot.
  always_ff @(posedge clk) begin
    a_tot_r <= snap;
    b_tot_r <= a_tot_r;
  end

  lrm_avg_lane u_lane_sent_frame (
    .clk(clk), .rst_n(rst_n), .clear(clear_acc), .ctl(lane_ctl),
    .x(x.sent_frame), .avg_new(avg_new.sent_frame)
  );

  lrm_avg_lane u_lane_recv_frame (
    .clk(clk), .rst_n(rst_n), .clear(clear_acc), .ctl(lane_ctl),
    .x(x.recv_frame), .avg_new(avg_new.recv_frame)
  );

  lrm_avg_lane u_lane_sent_byte (
    .clk(clk), .rst_n(rst_n), .clear(clear_acc), .ctl(lane_ctl),
    .x(x.sent_byte), .avg_new(avg_new.sent_byte)
  );

  lrm_avg_lane u_lane_recv_byte (
    .clk(clk), .rst_n(rst_n), .clear(clear_acc), .ctl(lane_ctl),
    .x(x.recv_byte), .avg_new(avg_new.recv_byte)
  );

  assign res.idx    = b_ctl_r.idx;
  assign res.rates  = avg_new;
  assign res.totals = b_tot_r;
  assign res.last   = (b_ctl_r.idx == FINAL_SLOT);

  lrm_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (b_ctl_r.vld),
    .wdata    (res),
    .pop      (out_pop),
    .rdata    (head),
    .not_empty(out_valid)
  );

  assign out_pop = out_valid && !out_stall;

  assign out_interval_index  = head.idx;
  assign out_sent_frame_rate = head.rates.sent_frame;
  assign out_recv_frame_rate = head.rates.recv_frame;
  assign out_sent_byte_rate  = head.rates.sent_byte;
  assign out_recv_byte_rate  = head.rates.recv_byte;
  assign out_sent_frames     = head.totals.sent_frames;
  assign out_recv_frames     = head.totals.recv_frames;
  assign out_send_failures   = head.totals.send_failures;
  assign out_sent_bytes      = head.totals.sent_bytes;
  assign out_recv_bytes      = head.totals.recv_bytes;
  assign out_last            = head.last;

endmodule
`default_nettype wire

FILE: rtl/lrm_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Link traffic rate meter: port checker
// Watches the ports of the rate meter for ordering and hold-off rules.
// ----------------------------------------------------------------------------
module lrm_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_stall,
  input wire logic [lrm_pkg::REQ_W-1:0] in_req_type,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire logic [lrm_pkg::IDX_W-1:0] out_interval_index,
  input wire logic [lrm_pkg::CNT_W-1:0] out_sent_frame_rate,
  input wire logic [lrm_pkg::CNT_W-1:0] out_sent_frames,
  input wire logic [lrm_pkg::CNT_W-1:0] out_recv_bytes,
  input wire logic                      out_last
);
  import lrm_pkg::*;

  // Counting words are never held back.
  a_only_tick_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |-> (in_req_type == REQ_TICK || in_req_type == REQ_CLEAR))
    else $error("a counting word was stalled");

  // Within a tick the interval index steps up by one.
  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=>
      (!out_valid || out_interval_index == $past(out_interval_index) + 1'b1))
    else $error("interval index did not step within a tick");

  // A new tick starts at the first interval.
  a_index_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last |=> (!out_valid || out_interval_index == '0))
    else $error("tick did not start at the first interval");

  // All words of one tick report the same sent-frame and received-byte totals.
  a_totals_per_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=>
      (!out_valid || (out_sent_frames == $past(out_sent_frames) &&
                      out_recv_bytes == $past(out_recv_bytes))))
    else $error("totals changed within a tick");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_interval_index) && $stable(out_sent_frame_rate))
    else $error("stalled result word changed");

endmodule

bind link_traffic_rate_meter lrm_checker u_lrm_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .in_req_type        (in_req_type),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_interval_index (out_interval_index),
  .out_sent_frame_rate(out_sent_frame_rate),
  .out_sent_frames    (out_sent_frames),
  .out_recv_bytes     (out_recv_bytes),
  .out_last           (out_last)
);
`default_nettype wire
